>>> rtl/lsm_pkg.sv
package lsm_pkg;

  localparam int VECTOR_LEN = 64;
  localparam int ADDR_W     = 6;
  localparam int CNT_W      = 7;
  localparam int SCORE_W    = 16;
  localparam int E_W        = 17;
  localparam int SUM_W      = 23;
  localparam int LSE_W      = 12;
  localparam logic [16:0] LN2_Q16 = 17'd45426;

  typedef logic signed [SCORE_W-1:0] score_t;

  function automatic logic [E_W-1:0] expk_lut(input logic [7:0] k);
    logic [E_W-1:0] r;
    unique case (k)
      8'd0:    r = 17'd65536;
      8'd1:    r = 17'd24109;
      8'd2:    r = 17'd8869;
      8'd3:    r = 17'd3263;
      8'd4:    r = 17'd1200;
      8'd5:    r = 17'd442;
      8'd6:    r = 17'd162;
      8'd7:    r = 17'd60;
      8'd8:    r = 17'd22;
      8'd9:    r = 17'd8;
      8'd10:   r = 17'd3;
      8'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] exph_lut(input logic [3:0] h);
    logic [15:0] r;
    unique case (h)
      4'd0:  r = 16'd65535;
      4'd1:  r = 16'd61565;
      4'd2:  r = 16'd57835;
      4'd3:  r = 16'd54331;
      4'd4:  r = 16'd51039;
      4'd5:  r = 16'd47947;
      4'd6:  r = 16'd45042;
      4'd7:  r = 16'd42313;
      4'd8:  r = 16'd39750;
      4'd9:  r = 16'd37341;
      4'd10: r = 16'd35079;
      4'd11: r = 16'd32954;
      4'd12: r = 16'd30957;
      4'd13: r = 16'd29081;
      4'd14: r = 16'd27319;
      4'd15: r = 16'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] expl_lut(input logic [3:0] l);
    logic [15:0] r;
    unique case (l)
      4'd0:  r = 16'd65535;
      4'd1:  r = 16'd65280;
      4'd2:  r = 16'd65026;
      4'd3:  r = 16'd64772;
      4'd4:  r = 16'd64520;
      4'd5:  r = 16'd64268;
      4'd6:  r = 16'd64018;
      4'd7:  r = 16'd63768;
      4'd8:  r = 16'd63520;
      4'd9:  r = 16'd63272;
      4'd10: r = 16'd63025;
      4'd11: r = 16'd62780;
      4'd12: r = 16'd62535;
      4'd13: r = 16'd62291;
      4'd14: r = 16'd62048;
      4'd15: r = 16'd61806;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] lnt_lut(input logic [4:0] i);
    logic [15:0] r;
    unique case (i)
      5'd0:    r = 16'd0;
      5'd1:    r = 16'd3973;
      5'd2:    r = 16'd7719;
      5'd3:    r = 16'd11262;
      5'd4:    r = 16'd14624;
      5'd5:    r = 16'd17821;
      5'd6:    r = 16'd20870;
      5'd7:    r = 16'd23783;
      5'd8:    r = 16'd26573;
      5'd9:    r = 16'd29248;
      5'd10:   r = 16'd31818;
      5'd11:   r = 16'd34292;
      5'd12:   r = 16'd36675;
      5'd13:   r = 16'd38975;
      5'd14:   r = 16'd41196;
      5'd15:   r = 16'd43345;
      5'd16:   r = 16'd45426;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/lsm_exp.sv
module lsm_exp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [15:0]          m,
  output logic                 out_valid,
  output logic [lsm_pkg::E_W-1:0] e
);
  import lsm_pkg::*;

  logic           v1;
  logic [E_W-1:0] e1;
  logic [3:0]     l1;
  logic [E_W-1:0] e1_next;
  logic [E_W-1:0] e2_next;
  logic [33:0]    prod1;
  logic [33:0]    prod2;

  // exph/expl entry 0 is 65536; 65535 plus one keeps it in 16 bits
  always_comb begin
    prod1 = 34'(expk_lut(m[15:8])) * 34'(exph_lut(m[7:4]));
    if (m[7:4] == 4'd0) prod1 = prod1 + 34'(expk_lut(m[15:8]));
    prod1 = prod1 + 34'd32768;
    e1_next = prod1[32:16];
    prod2 = 34'(e1) * 34'(expl_lut(l1));
    if (l1 == 4'd0) prod2 = prod2 + 34'(e1);
    prod2 = prod2 + 34'd32768;
    e2_next = prod2[32:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    e1 <= e1_next;
    l1 <= m[3:0];
    e  <= e2_next;
  end

endmodule

>>> rtl/lsm_ln.sv
module lsm_ln (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [lsm_pkg::SUM_W-1:0]  sum,
  output logic                       out_valid,
  output logic [lsm_pkg::LSE_W-1:0]  lse
);
  import lsm_pkg::*;

  logic [2:0]       p;
  logic [SUM_W-1:0] s_clr;
  logic [SUM_W-1:0] s_shift;
  logic             va;
  logic             vb;
  logic [3:0]       ia;
  logic [11:0]      ta;
  logic [2:0]       pa;
  logic [2:0]       pb;
  logic [16:0]      frac;
  logic [15:0]      lo;
  logic [15:0]      hi;
  logic [29:0]      prod;
  logic [16:0]      frac_next;
  logic [19:0]      val;

  always_comb begin
    priority if (sum[22]) p = 3'd6;
    else if (sum[21])     p = 3'd5;
    else if (sum[20])     p = 3'd4;
    else if (sum[19])     p = 3'd3;
    else if (sum[18])     p = 3'd2;
    else if (sum[17])     p = 3'd1;
    else                  p = 3'd0;
    s_clr = sum & ~(SUM_W'(1) << (5'(p) + 5'd16));
    s_shift = s_clr >> p;
  end

  always_comb begin
    lo = lnt_lut({1'b0, ia});
    hi = lnt_lut(5'({1'b0, ia}) + 5'd1);
    prod = 30'(hi - lo) * 30'(ta) + 30'd2048;
    frac_next = 17'(lo) + 17'(prod[29:12]);
    val = 20'(pb) * 20'(LN2_Q16) + 20'(frac) + 20'd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
    ia   <= s_shift[15:12];
    ta   <= s_shift[11:0];
    pa   <= p;
    frac <= frac_next;
    pb   <= pa;
    lse  <= val[19:8];
  end

endmodule

>>> rtl/log_softmax_forward_top.sv
// after the last item of a column of n items, the column is read through the exp unit into
// the sum, the sum goes through the ln unit, and the column is read again; results then come
// one per cycle, n of them; the single score memory read port, read once for the exp sum and
// once more for the results, sets the column rate; busy holds off a new column until the last result
// reset: synchronous, clears the controller, the running max and the fill count
module log_softmax_forward_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lsm_pkg::score_t     score,
  input  logic                last,
  output logic                strobe,
  output lsm_pkg::score_t     log_prob,
  output logic [5:0]          position,
  output logic                final_res
);
  import lsm_pkg::*;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_SUM  = 2'd1;
  localparam logic [1:0] S_LN   = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  score_t           mem [VECTOR_LEN];
  score_t           rdata;
  logic [1:0]       state;
  score_t           running_max;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] rd_cnt;
  logic [CNT_W-1:0] acc_cnt;
  logic [ADDR_W-1:0] rpos;
  logic             re;
  logic             rvalid;
  logic [15:0]      m_reg;
  logic             m_valid;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic             exp_valid;
  logic [E_W-1:0]   exp_e;
  logic             ln_start;
  logic             ln_valid;
  logic [LSE_W-1:0] ln_lse;
  logic [LSE_W-1:0] lse;
  logic             accept;
  logic             close;
  logic [16:0]      diff;
  logic signed [17:0] y;

  assign busy     = (state != S_LOAD);
  assign accept   = start && !busy;
  assign close    = accept && (last || (fill == CNT_W'(VECTOR_LEN - 1)));
  assign re       = ((state == S_SUM) || (state == S_EMIT)) && (rd_cnt != n);
  assign sum_next = sum + SUM_W'(exp_e);
  assign ln_start = (state == S_SUM) && exp_valid && (acc_cnt + CNT_W'(1) == n);
  assign diff     = 17'({running_max[15], running_max}) - 17'({rdata[15], rdata});
  assign y        = 18'(signed'({{2{rdata[15]}}, rdata}))
                  - 18'(signed'({{2{running_max[15]}}, running_max}))
                  - 18'(signed'({6'd0, lse}));

  always_ff @(posedge clk) begin
    if (accept) mem[fill[ADDR_W-1:0]] <= score;
    if (re) rdata <= mem[rd_cnt[ADDR_W-1:0]];
  end

  lsm_exp u_exp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .m         (m_reg),
    .out_valid (exp_valid),
    .e         (exp_e)
  );

  lsm_ln u_ln (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ln_start),
    .sum       (sum_next),
    .out_valid (ln_valid),
    .lse       (ln_lse)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      running_max <= score_t'(16'sh8000);
      fill        <= '0;
      rd_cnt      <= '0;
      acc_cnt     <= '0;
      rvalid      <= 1'b0;
      m_valid     <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      rvalid  <= re;
      m_valid <= rvalid && (state == S_SUM);
      strobe  <= rvalid && (state == S_EMIT);
      if (re) rd_cnt <= rd_cnt + CNT_W'(1);
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            fill <= fill + CNT_W'(1);
            if (score > running_max) running_max <= score;
          end
          if (close) begin
            state   <= S_SUM;
            rd_cnt  <= '0;
            acc_cnt <= '0;
          end
        end
        S_SUM: begin
          if (exp_valid) acc_cnt <= acc_cnt + CNT_W'(1);
          if (ln_start) state <= S_LN;
        end
        S_LN: begin
          if (ln_valid) begin
            state  <= S_EMIT;
            rd_cnt <= '0;
          end
        end
        S_EMIT: begin
          if (rvalid) begin
            if (CNT_W'(rpos) + CNT_W'(1) == n) begin
              state       <= S_LOAD;
              fill        <= '0;
              running_max <= score_t'(16'sh8000);
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      n   <= fill + CNT_W'(1);
      sum <= '0;
    end else if (exp_valid) begin
      sum <= sum_next;
    end
    if (re) rpos <= rd_cnt[ADDR_W-1:0];
    if (rvalid) m_reg <= diff[15:0];
    if (ln_valid) lse <= ln_lse;
    if (y < -18'sd32768) log_prob <= score_t'(16'sh8000);
    else log_prob <= y[15:0];
    position  <= rpos;
    final_res <= (CNT_W'(rpos) + CNT_W'(1) == n);
  end

endmodule

>>> test/testbench.sv
module testbench;

  import lsm_pkg::*;

  localparam longint LOG_TWO_Q16 = 45426;

  typedef struct {
    score_t     log_prob;
    logic [5:0] position;
    logic       final_res;
  } prob_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  score_t     score;
  logic       last;
  logic       strobe;
  score_t     log_prob;
  logic [5:0] position;
  logic       final_res;

  log_softmax_forward_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .score     (score),
    .last      (last),
    .strobe    (strobe),
    .log_prob  (log_prob),
    .position  (position),
    .final_res (final_res)
  );

  // exp(-k), exp(-h/16), exp(-l/256) and ln(1 + i/16), all Q16
  longint exp_int_tab [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
  longint exp_hi_tab [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                              39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
  longint exp_lo_tab [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                              63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};
  longint ln_tab [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
                          29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

  score_t col_buf [VECTOR_LEN];
  int     col_fill;
  int     col_max;
  prob_t  expected_probs [$];
  int     errors;
  bit     no_gaps;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #3_000_000;
    $display("log_softmax_forward_top regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // exp(-m/256) in Q16
  function automatic longint exp_term(input logic [15:0] m);
    longint e;
    if (m[15:8] >= 12) return 0;
    e = (exp_int_tab[m[15:8]] * exp_hi_tab[m[7:4]] + 32768) >> 16;
    e = (e * exp_lo_tab[m[3:0]] + 32768) >> 16;
    return e;
  endfunction

  // ln of a Q16 sum, answered in Q8.8
  function automatic longint ln_q8(input longint s);
    longint p;
    longint f;
    longint i;
    longint t;
    longint frac;
    p = 16;
    for (int q = 17; q <= 22; q++) begin
      if (s[q]) p = q;
    end
    f = ((s - (longint'(1) << p)) >> (p - 16)) & 16'hFFFF;
    i = f >> 12;
    t = f & 4095;
    frac = ln_tab[i] + (((ln_tab[i+1] - ln_tab[i]) * t + 2048) >> 12);
    return ((p - 16) * LOG_TWO_Q16 + frac + 128) >> 8;
  endfunction

  task automatic absorb_score(input score_t s, input logic lst);
    longint exp_sum;
    longint lse;
    longint y;
    prob_t  r;
    col_buf[col_fill] = s;
    col_fill++;
    if (s > col_max) col_max = s;
    if (!lst && col_fill < VECTOR_LEN) return;
    exp_sum = 0;
    for (int j = 0; j < col_fill; j++) begin
      exp_sum += exp_term(16'(col_max - col_buf[j]));
    end
    lse = ln_q8(exp_sum);
    for (int j = 0; j < col_fill; j++) begin
      y = longint'(col_buf[j]) - col_max - lse;
      if (y < -32768) y = -32768;
      r.log_prob  = y[15:0];
      r.position  = j[5:0];
      r.final_res = (j == col_fill - 1);
      expected_probs.push_back(r);
    end
    col_max  = -32768;
    col_fill = 0;
  endtask

  always @(posedge clk) begin
    prob_t r;
    if (!rst && strobe) begin
      if (expected_probs.size() == 0) begin
        report_mismatch($sformatf("unexpected result log_prob %0d position %0d final %0b",
                                  log_prob, position, final_res));
      end else begin
        r = expected_probs.pop_front();
        if (log_prob !== r.log_prob || position !== r.position ||
            final_res !== r.final_res) begin
          report_mismatch($sformatf("got log_prob %0d position %0d final %0b, want %0d %0d %0b",
                                    log_prob, position, final_res,
                                    r.log_prob, r.position, r.final_res));
        end
      end
    end
  end

  task automatic send_score(input score_t s, input logic lst);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    score = s;
    last  = lst;
    do @(posedge clk); while (busy);
    absorb_score(s, lst);
  endtask

  task automatic send_column(input score_t vals [$]);
    foreach (vals[j]) send_score(vals[j], j == vals.size() - 1);
  endtask

  task automatic test_single_scores();
    score_t vals [$];
    vals = '{16'sd0, 16'sd32767, -16'sd32768, -16'sd1};
    foreach (vals[j]) send_score(vals[j], 1'b1);
  endtask

  task automatic test_extremes();
    send_column('{16'sd32767, -16'sd32768, 16'sd0, 16'sd256, -16'sd256, 16'sd1});
  endtask

  task automatic test_equal_scores();
    send_column('{16'sh0A5A, 16'sh0A5A, 16'sh0A5A, 16'sh0A5A});
  endtask

  // distances that cross the exp table boundaries, the farthest one adds nothing
  task automatic test_exp_range();
    send_column('{16'sd1000, 16'sd745, 16'sd744, -16'sd1815, -16'sd2071, -16'sd2072});
  endtask

  // a column that fills the buffer closes without last
  task automatic test_full_column();
    score_t base;
    base = score_t'($urandom);
    for (int j = 0; j < VECTOR_LEN; j++) begin
      send_score(base - score_t'($urandom_range(0, 3200)), 1'b0);
    end
    send_column('{score_t'($urandom), score_t'($urandom)});
  endtask

  task automatic test_random_columns();
    int     sent;
    int     len;
    int     sel;
    bit     near;
    score_t base;
    score_t s;
    sent = 0;
    while (sent < 80) begin
      sel = $urandom_range(0, 19);
      if (sel < 17) len = $urandom_range(1, 12);
      else if (sel < 19) len = $urandom_range(13, 63);
      else len = VECTOR_LEN;
      near    = $urandom_range(0, 2) != 0;
      base    = score_t'($urandom);
      no_gaps = $urandom_range(0, 3) == 0;
      for (int j = 0; j < len; j++) begin
        s = near ? base - score_t'($urandom_range(0, 3200)) : score_t'($urandom);
        send_score(s, j == len - 1 ? 1'b1 : 1'($urandom_range(0, 15) == 0));
      end
      sent += len;
    end
    no_gaps = 1'b0;
    // close any column left open by an early last
    if (col_fill != 0) send_score(score_t'($urandom), 1'b1);
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    score    = '0;
    last     = 1'b0;
    errors   = 0;
    no_gaps  = 1'b0;
    col_fill = 0;
    col_max  = -32768;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_single_scores();
    test_extremes();
    test_equal_scores();
    test_exp_range();
    test_full_column();
    test_random_columns();

    @(negedge clk);
    start = 1'b0;
    for (int c = 0; c < 20000 && expected_probs.size() != 0; c++) @(posedge clk);
    repeat (100) @(posedge clk);
    if (expected_probs.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_probs.size()));
    end
    if (errors == 0) begin
      $display("log_softmax_forward_top regression: pass");
    end else begin
      $display("log_softmax_forward_top regression: fail");
    end
    $finish;
  end

endmodule
